>>> sv/pwbm_pkg.sv
// Package for the profile window best match unit.
// Holds sizes, codes, channel structs and the saturation helpers.
// No dependencies.
package pwbm_pkg;

  localparam int TEMPLATE_MAX  = 32;
  localparam int MAX_SEQ_LEN   = 2048;
  localparam int ALPHABET_SIZE = 21;
  localparam int CHAIN_COUNT   = 3;
  localparam int SCORE_WIDTH   = 16;

  localparam int TAIL_DROP = 5;
  localparam int CYS_CODE  = 1;
  localparam int NCELL     = (TEMPLATE_MAX > TAIL_DROP) ? TEMPLATE_MAX : TAIL_DROP + 1;
  localparam int CELL_W    = $clog2(NCELL);
  localparam int TLW       = $clog2(TEMPLATE_MAX + 1);
  localparam int CNT_W     = $clog2(MAX_SEQ_LEN + 2);
  localparam int CMP_W     = CNT_W + 8;
  localparam int ALPHA_AW  = $clog2(ALPHABET_SIZE);

  localparam int SUM_W     = 21;
  localparam int START_W   = 11;
  localparam int OSCORE_W  = 20;
  localparam int TLEN_W    = 6;
  localparam int MINLEN_W  = 12;
  localparam int RES_W     = 5;
  localparam int TPOS_W    = 5;
  localparam int TRES_W    = 5;
  localparam int TCH_W     = 2;
  localparam int TVAL_W    = 16;
  localparam int STATUS_W  = 2;
  localparam int OUT_CHAINS = 3;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 96;
  localparam int CFG_DATA_W = 12;
  localparam int OUT_LANE_W = OSCORE_W + START_W;

  localparam logic MODE_SEQ   = 1'b0;
  localparam logic MODE_TABLE = 1'b1;

  localparam logic CFG_TLEN   = 1'b0;
  localparam logic CFG_MINLEN = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_BAD    = 2'd1,
    STAT_FEWCYS = 2'd2
  } status_t;

  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic signed [SCORE_WIDTH-1:0] score_t;

  typedef struct packed {
    logic                                valid;
    logic [START_W-1:0]                  start;
    logic [CHAIN_COUNT-1:0][SUM_W-1:0]   sums;
  } win_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic add;
  } cell_ctl_t;

  typedef struct packed {
    logic [CHAIN_COUNT-1:0] en;
    logic [ALPHA_AW-1:0]    addr;
    logic [SCORE_WIDTH-1:0] data;
  } tbl_wr_t;

  function automatic logic [SCORE_WIDTH-1:0] sat_score(input logic [TVAL_W-1:0] v);
    logic signed [33:0] x;
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    x  = 34'($signed(v));
    hi = (34'sd1 <<< (SCORE_WIDTH - 1)) - 34'sd1;
    lo = -(34'sd1 <<< (SCORE_WIDTH - 1));
    if (x > hi) x = hi;
    if (x < lo) x = lo;
    return x[SCORE_WIDTH-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                               input logic [SCORE_WIDTH-1:0] v);
    logic signed [33:0] t;
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    t  = 34'($signed(s)) + 34'($signed(v));
    hi = (34'sd1 <<< (SUM_W - 1)) - 34'sd1;
    lo = -(34'sd1 <<< (SUM_W - 1));
    if (t > hi) t = hi;
    if (t < lo) t = lo;
    return t[SUM_W-1:0];
  endfunction

endpackage

>>> sv/pwbm_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
module pwbm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/pwbm_cell.sv
// One template-position cell: score table column and one window in flight.
// Depends on pwbm_pkg and pwbm_ram.
module pwbm_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pwbm_pkg::tbl_wr_t           tbl_wr,
  input  logic                        rd_en,
  input  logic [pwbm_pkg::ALPHA_AW-1:0] rd_addr,
  input  pwbm_pkg::cell_ctl_t         ctl,
  input  pwbm_pkg::win_t              win_i,
  output pwbm_pkg::win_t              win_o
);
  import pwbm_pkg::*;

  logic [SCORE_WIDTH-1:0] tbl [CHAIN_COUNT];
  win_t win_r;
  win_t win_nxt;

  for (genvar k = 0; k < CHAIN_COUNT; k++) begin : g_chain
    pwbm_ram #(
      .WIDTH(SCORE_WIDTH),
      .DEPTH(ALPHABET_SIZE)
    ) u_ram (
      .clk   (clk),
      .we    (tbl_wr.en[k]),
      .waddr (tbl_wr.addr),
      .wdata (tbl_wr.data),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (tbl[k])
    );
  end

  always_comb begin
    win_nxt = win_r;
    if (ctl.clear) begin
      win_nxt.valid = 1'b0;
    end else if (ctl.shift) begin
      win_nxt.valid = win_i.valid;
      win_nxt.start = win_i.start;
      for (int k = 0; k < CHAIN_COUNT; k++) begin
        win_nxt.sums[k] = ctl.add ? sat_add(win_i.sums[k], tbl[k]) : win_i.sums[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else begin
      win_r <= win_nxt;
    end
  end

  assign win_o = win_r;

endmodule

>>> sv/profile_window_best_match_unit.sv
// Top level of the profile window best match unit: sequencing, chain, judge, result.
// Depends on pwbm_pkg and pwbm_cell.
//
//   channel | direction | tdata                         | tuser  | tlast
//   in_     | slave     | residue, table pos/res/chain/ | mode   | last
//           |           | value                         |        |
//   out_    | master    | score/start for chains a,b,c  | status | -
//   cfg_    | slave     | cfg_index, cfg_data           | -      | -
//
// One item per cycle inside a sequence; table writes also one per cycle.
// After the last residue the window chain shifts and drains to the judged cell, then
// the judge and result load follow; input is held off until the result is loaded.
// The result register lets the next sequence start while a result waits.
// Reset is synchronous; the score table is not cleared by reset.
module profile_window_best_match_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [4:0] residue, [9:5] table_position, [14:10] table_residue,
  // [16:15] table_chain, [32:17] table_value, [39:33] zero
  input  logic [pwbm_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] mode
  input  logic                            in_tuser,
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [19:0] best_score_a, [30:20] best_start_a, [50:31] best_score_b,
  // [61:51] best_start_b, [81:62] best_score_c, [92:82] best_start_c, [95:93] zero
  output logic [pwbm_pkg::OUT_DATA_W-1:0] out_tdata,
  // [1:0] status
  output logic [pwbm_pkg::STATUS_W-1:0]   out_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [pwbm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pwbm_pkg::*;

  typedef enum logic [1:0] {S_RUN, S_DRAIN, S_FLUSH} state_t;

  state_t               state_r;
  logic [TLEN_W-1:0]    tlen_cfg_r;
  logic [MINLEN_W-1:0]  minlen_r;
  logic [CNT_W-1:0]     count_r;
  logic [1:0]           cys_r;
  logic                 bad_r;
  logic [TLW-1:0]       tlen_r;
  logic [CELL_W-1:0]    delay_r;
  logic [CELL_W-1:0]    drain_r;
  logic                 s1_go_r;
  logic                 s1_open_r;
  logic                 s1_add_r;
  logic [START_W-1:0]   s1_start_r;
  logic                 jd_go_r;
  status_t              status_pend_r;
  logic [SUM_W-1:0]     best_sum_r [CHAIN_COUNT];
  logic [START_W-1:0]   best_start_r [CHAIN_COUNT];
  logic [SUM_W-1:0]     best_sum_nxt [CHAIN_COUNT];
  logic [START_W-1:0]   best_start_nxt [CHAIN_COUNT];
  logic                 out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;
  status_t              out_status_r;

  logic                 in_fire, seq_fire, tbl_fire;
  logic [RES_W-1:0]     res;
  logic [TPOS_W-1:0]    tpos;
  logic [TRES_W-1:0]    tres;
  logic [TCH_W-1:0]     tch;
  logic [TVAL_W-1:0]    tval;
  logic                 res_ok, in_range, scored;
  logic [TLW-1:0]       tlen_eff, tl;
  logic [CELL_W-1:0]    dly;
  logic [CNT_W-1:0]     len_nxt;
  logic [1:0]           cys_nxt;
  logic                 bad_nxt;
  status_t              status_nxt;
  logic                 drain_shift, shift, flush_go;
  win_t                 fresh;
  win_t                 win [NCELL];
  win_t                 sel;

  assign in_fire  = in_tvalid & in_tready;
  assign seq_fire = in_fire & (in_tuser == MODE_SEQ);
  assign tbl_fire = in_fire & (in_tuser == MODE_TABLE);

  assign res  = in_tdata[4:0];
  assign tpos = in_tdata[9:5];
  assign tres = in_tdata[14:10];
  assign tch  = in_tdata[16:15];
  assign tval = in_tdata[32:17];

  assign res_ok   = res < RES_W'(ALPHABET_SIZE);
  assign in_range = count_r < CNT_W'(MAX_SEQ_LEN);
  assign scored   = res_ok & in_range;

  always_comb begin
    if (tlen_cfg_r == '0) begin
      tlen_eff = TLW'(1);
    end else if (8'(tlen_cfg_r) > 8'(TEMPLATE_MAX)) begin
      tlen_eff = TLW'(TEMPLATE_MAX);
    end else begin
      tlen_eff = TLW'(tlen_cfg_r);
    end
    tl  = (count_r == '0) ? tlen_eff : tlen_r;
    dly = (8'(tl) - 8'd1 > 8'(TAIL_DROP)) ? CELL_W'(tl - TLW'(1)) : CELL_W'(TAIL_DROP);
    len_nxt = (count_r <= CNT_W'(MAX_SEQ_LEN)) ? count_r + CNT_W'(1) : count_r;
    cys_nxt = (scored && res == RES_W'(CYS_CODE) && cys_r != 2'd2) ? cys_r + 2'd1 : cys_r;
    bad_nxt = bad_r | (in_range & ~res_ok);
    if (CMP_W'(len_nxt) < CMP_W'(minlen_r) || CMP_W'(len_nxt) <= CMP_W'(tl) ||
        CMP_W'(len_nxt) > CMP_W'(MAX_SEQ_LEN) || bad_nxt) begin
      status_nxt = STAT_BAD;
    end else if (cys_nxt != 2'd2) begin
      status_nxt = STAT_FEWCYS;
    end else begin
      status_nxt = STAT_OK;
    end
  end

  assign in_tready   = (state_r == S_RUN);
  assign cfg_ready   = 1'b1;
  assign drain_shift = (state_r == S_DRAIN) & ~s1_go_r & (drain_r != '0);
  assign shift       = s1_go_r | drain_shift;
  assign flush_go    = (state_r == S_FLUSH) & (~out_valid_r | out_tready);

  always_comb begin
    fresh       = '0;
    fresh.valid = s1_go_r & s1_open_r;
    fresh.start = s1_start_r;
  end

  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    tbl_wr_t   wr;
    cell_ctl_t ctl;
    win_t      win_in;

    always_comb begin
      wr.addr = ALPHA_AW'(tres);
      wr.data = sat_score(tval);
      for (int k = 0; k < CHAIN_COUNT; k++) begin
        wr.en[k] = tbl_fire && (j < TEMPLATE_MAX) && (8'(tpos) == 8'(j)) &&
                   (tres < TRES_W'(ALPHABET_SIZE)) && (tch == TCH_W'(k));
      end
      ctl.shift = shift;
      ctl.clear = flush_go;
      ctl.add   = s1_go_r & s1_add_r & (8'(j) < 8'(tlen_r));
    end

    if (j == 0) begin : g_head
      assign win_in = fresh;
    end else begin : g_link
      assign win_in = win[j-1];
    end

    pwbm_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tbl_wr  (wr),
      .rd_en   (seq_fire & res_ok),
      .rd_addr (ALPHA_AW'(res)),
      .ctl     (ctl),
      .win_i   (win_in),
      .win_o   (win[j])
    );
  end

  assign sel = win[delay_r];

  always_comb begin
    for (int k = 0; k < CHAIN_COUNT; k++) begin
      best_sum_nxt[k]   = best_sum_r[k];
      best_start_nxt[k] = best_start_r[k];
      if (flush_go) begin
        best_sum_nxt[k]   = '0;
        best_start_nxt[k] = '0;
      end else if (jd_go_r && sel.valid &&
                   $signed(sel.sums[k]) > $signed(best_sum_r[k])) begin
        best_sum_nxt[k]   = sel.sums[k];
        best_start_nxt[k] = sel.start;
      end
    end
  end

  always_comb begin
    out_data_nxt = '0;
    for (int k = 0; k < OUT_CHAINS; k++) begin
      if (k < CHAIN_COUNT && status_pend_r == STAT_OK) begin
        out_data_nxt[k*OUT_LANE_W +: OSCORE_W]           = best_sum_r[k][OSCORE_W-1:0];
        out_data_nxt[k*OUT_LANE_W + OSCORE_W +: START_W] = best_start_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_RUN;
      tlen_cfg_r    <= TLEN_W'(32);
      minlen_r      <= '0;
      count_r       <= '0;
      cys_r         <= '0;
      bad_r         <= 1'b0;
      tlen_r        <= TLW'(1);
      delay_r       <= CELL_W'(TAIL_DROP);
      drain_r       <= '0;
      s1_go_r       <= 1'b0;
      jd_go_r       <= 1'b0;
      status_pend_r <= STAT_OK;
      out_valid_r   <= 1'b0;
      out_status_r  <= STAT_OK;
      for (int k = 0; k < CHAIN_COUNT; k++) begin
        best_sum_r[k]   <= '0;
        best_start_r[k] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TLEN:   tlen_cfg_r <= cfg_data[TLEN_W-1:0];
          CFG_MINLEN: minlen_r   <= cfg_data[MINLEN_W-1:0];
          default:    ;
        endcase
      end

      s1_go_r <= seq_fire;
      jd_go_r <= shift;
      for (int k = 0; k < CHAIN_COUNT; k++) begin
        best_sum_r[k]   <= best_sum_nxt[k];
        best_start_r[k] <= best_start_nxt[k];
      end

      if (seq_fire) begin
        s1_open_r  <= scored & (cys_r == 2'd2);
        s1_add_r   <= scored;
        s1_start_r <= START_W'(count_r);
        tlen_r     <= tl;
        delay_r    <= dly;
        if (in_tlast) begin
          count_r       <= '0;
          cys_r         <= '0;
          bad_r         <= 1'b0;
          status_pend_r <= status_nxt;
          drain_r       <= dly - CELL_W'(TAIL_DROP);
        end else begin
          count_r <= len_nxt;
          cys_r   <= cys_nxt;
          bad_r   <= bad_nxt;
        end
      end

      case (state_r)
        S_RUN: begin
          if (seq_fire && in_tlast) state_r <= S_DRAIN;
        end
        S_DRAIN: begin
          if (drain_shift) drain_r <= drain_r - CELL_W'(1);
          if (!s1_go_r && drain_r == '0) state_r <= S_FLUSH;
        end
        S_FLUSH: begin
          if (flush_go) state_r <= S_RUN;
        end
        default: state_r <= S_RUN;
      endcase

      if (flush_go) begin
        out_valid_r  <= 1'b1;
        out_status_r <= status_pend_r;
        out_data_r   <= out_data_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule

>>> sv/pwbm_checker.sv
// Port-level checks for the profile window best match unit, bound to the top.
// Depends on pwbm_pkg and profile_window_best_match_unit.
module pwbm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [pwbm_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                            in_tuser,
  input logic                            in_tlast,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [pwbm_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [pwbm_pkg::STATUS_W-1:0]   out_tuser
);
  import pwbm_pkg::*;

  logic last_fire;
  assign last_fire = in_tvalid && in_tready && (in_tuser == MODE_SEQ) && in_tlast;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != STAT_OK) |-> out_tdata == '0)
    else $error("error result carries nonzero data");

  a_hold_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    last_fire |=> !in_tready ##1 !in_tready)
    else $error("input taken during result drain");

  a_rise_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without a drain");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind profile_window_best_match_unit pwbm_checker u_pwbm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
